[rtl/obfc_pkg.sv]
// -----------------------------------------------------------------------------
// obfc_pkg
// Shared types and codes of the oriented box frustum cull block.
// -----------------------------------------------------------------------------
package obfc_pkg;

	localparam logic [1:0] FUNC_CULL   = 2'd0;
	localparam logic [1:0] FUNC_ORIENT = 2'd1;
	localparam logic [1:0] FUNC_PLANE  = 2'd2;

	localparam logic [1:0] VERDICT_INSIDE  = 2'd0;
	localparam logic [1:0] VERDICT_CLIP    = 2'd1;
	localparam logic [1:0] VERDICT_OUTSIDE = 2'd2;

	localparam int ORIENT_WORDS = 12;

	typedef logic signed [31:0] word_t;

	typedef enum logic [1:0] {
		OP_CULL,
		OP_ORIENT,
		OP_PLANE
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [3:0]  idx;
		word_t       value;
		word_t [2:0] bmin;
		word_t [2:0] bmax;
	} item_t;

endpackage

[rtl/oriented_box_frustum_cull_top.sv]
// Sequence: a cull item visits the 8 corners in turn; for each it forms the three
//   world coordinates (multiply, then sum) and tests every plane (multiply,
//   then compare). A no_cull item skips the corner and plane work.
// Flow: one cull runs at a time on the shared transform and dot multipliers; the
//   back end takes items only when idle, and then retires one load per cycle.
// Reset: arst_n clears no_cull, the queue and both stores to zero at once.
// -----------------------------------------------------------------------------
// oriented_box_frustum_cull_top
// Culls a local-space box against frustum planes as inside, clipped or outside.
// -----------------------------------------------------------------------------
module oriented_box_frustum_cull_top #(
	parameter int PLANES    = 4,
	parameter int FRAC_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	// input items
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [1:0]      func,
	input  logic [3:0]      word_index,
	input  obfc_pkg::word_t word_value,
	input  obfc_pkg::word_t box_min_x,
	input  obfc_pkg::word_t box_min_y,
	input  obfc_pkg::word_t box_min_z,
	input  obfc_pkg::word_t box_max_x,
	input  obfc_pkg::word_t box_max_y,
	input  obfc_pkg::word_t box_max_z,
	// result items
	output logic            out_valid,
	input  logic            out_stall,
	output logic [1:0]      verdict,
	// no_cull register write
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic            cfg_data
);
	import obfc_pkg::*;

	logic  q_valid;
	item_t q_item;
	logic  q_take;
	logic  no_cull_q;

	// Take register writes at any time; landing them only while idle is up to the user, the block does not enforce it.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			no_cull_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			no_cull_q <= cfg_data;
		end
	end

	// Front: accept items, drop unused codes and out-of-range loads, queue the rest.
	obfc_front #(
		.PLANES(PLANES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.word_index(word_index),
		.word_value(word_value),
		.box_min_x (box_min_x),
		.box_min_y (box_min_y),
		.box_min_z (box_min_z),
		.box_max_x (box_max_x),
		.box_max_y (box_max_y),
		.box_max_z (box_max_z),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_take    (q_take)
	);

	// Back: apply loads in order, and run each cull one corner at a time.
	obfc_back #(
		.PLANES   (PLANES),
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_take   (q_take),
		.no_cull  (no_cull_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.verdict  (verdict)
	);

endmodule

[rtl/obfc_front.sv]
// -----------------------------------------------------------------------------
// obfc_front
// Accepts items, drops the ones that do nothing and queues the rest.
// -----------------------------------------------------------------------------
module obfc_front #(
	parameter int PLANES = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          func,
	input  logic [3:0]          word_index,
	input  obfc_pkg::word_t     word_value,
	input  obfc_pkg::word_t     box_min_x,
	input  obfc_pkg::word_t     box_min_y,
	input  obfc_pkg::word_t     box_min_z,
	input  obfc_pkg::word_t     box_max_x,
	input  obfc_pkg::word_t     box_max_y,
	input  obfc_pkg::word_t     box_max_z,
	output logic                q_valid,
	output obfc_pkg::item_t     q_item,
	input  logic                q_take
);
	import obfc_pkg::*;

	item_t      mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       accept;
	logic       keep;
	item_t      item;

	assign in_stall = (cnt_q == 2'd2);
	assign accept   = in_valid && !in_stall;

	// classify: keep culls and in-range loads
	always_comb begin
		keep    = 1'b0;
		item.op = OP_CULL;
		case (func)
			FUNC_CULL: begin
				keep = 1'b1;
			end
			FUNC_ORIENT: begin
				keep    = (32'(word_index) < ORIENT_WORDS);
				item.op = OP_ORIENT;
			end
			FUNC_PLANE: begin
				keep    = (32'(word_index[3:2]) < PLANES);
				item.op = OP_PLANE;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
		item.idx     = word_index;
		item.value   = word_value;
		item.bmin    = {box_min_z, box_min_y, box_min_x};
		item.bmax    = {box_max_z, box_max_y, box_max_x};
	end

	always_ff @(posedge clk) begin
		if (accept && keep) begin
			mem_q[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (accept && keep) wr_q <= !wr_q;
			if (q_take) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(accept && keep) - 2'(q_take);
		end
	end

	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = mem_q[rd_q];

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue count out of range");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!q_valid |-> !q_take) else $error("pop from empty queue");
	a_drop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !keep && !q_take) |=> cnt_q == $past(cnt_q))
		else $error("dropped item changed queue");
`endif

endmodule

[rtl/obfc_back.sv]
// -----------------------------------------------------------------------------
// obfc_back
// Holds the stores, runs loads and sequences the corner transform and plane tests.
// -----------------------------------------------------------------------------
module obfc_back #(
	parameter int PLANES    = 4,
	parameter int FRAC_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  obfc_pkg::item_t q_item,
	output logic            q_take,
	input  logic            no_cull,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [1:0]      verdict
);
	import obfc_pkg::*;

	localparam int PW = (PLANES > 1) ? $clog2(PLANES) : 1;
	localparam int SW = 67;
	localparam int DW = 66;
	localparam logic signed [SW-1:0] SAT_HI = SW'(64'sd2147483647);
	localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);
	localparam logic signed [SW-1:0] HALF   = SW'(1) <<< (FRAC_BITS - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_XMUL = 3'd1;
	localparam logic [2:0] ST_XSUM = 3'd2;
	localparam logic [2:0] ST_DMUL = 3'd3;
	localparam logic [2:0] ST_DCMP = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0]         state_q;
	logic [2:0]         k_q;
	logic [1:0]         c_q;
	logic [PW-1:0]      p_q;
	word_t [2:0]        bmin_q;
	word_t [2:0]        bmax_q;
	word_t              orient_q [ORIENT_WORDS];
	word_t [3:0]        plane_q [PLANES];
	logic signed [63:0] prod_q [3];
	word_t [2:0]        pt_q;
	logic [PLANES-1:0]  front_q;
	logic [PLANES-1:0]  back_q;
	logic               forced_q;
	logic               res_valid_q;
	logic [1:0]         verdict_q;

	word_t              loc [3];
	word_t              axis [3];
	logic signed [SW-1:0] xsum;
	logic signed [SW-1:0] xshift;
	word_t              xsat;
	logic signed [DW-1:0] dot;
	logic signed [DW-1:0] plane_dist;
	logic               gt;
	logic [1:0]         final_verdict;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			loc[i]  = k_q[i] ? bmax_q[i] : bmin_q[i];
			axis[i] = orient_q[4'(3 + 3 * i) + 4'(c_q)];
		end
		xsum = (SW'(orient_q[{2'b00, c_q}]) <<< FRAC_BITS) + SW'(prod_q[0])
			+ SW'(prod_q[1]) + SW'(prod_q[2]) + HALF;
		xshift = xsum >>> FRAC_BITS;
		if (xshift > SAT_HI) xsat = 32'sh7fffffff;
		else if (xshift < SAT_LO) xsat = 32'sh80000000;
		else xsat = xshift[31:0];
		dot        = DW'(prod_q[0]) + DW'(prod_q[1]) + DW'(prod_q[2]);
		plane_dist = DW'(plane_q[p_q][3]) <<< FRAC_BITS;
		gt         = dot > plane_dist;
		if (forced_q) final_verdict = VERDICT_CLIP;
		else if (|(~front_q)) final_verdict = VERDICT_OUTSIDE;
		else if (|back_q) final_verdict = VERDICT_CLIP;
		else final_verdict = VERDICT_INSIDE;
	end

	assign q_take    = (state_q == ST_IDLE) && q_valid;
	assign out_valid = res_valid_q;
	assign verdict   = verdict_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			c_q         <= '0;
			p_q         <= '0;
			front_q     <= '0;
			back_q      <= '0;
			forced_q    <= 1'b0;
			res_valid_q <= 1'b0;
			verdict_q   <= VERDICT_INSIDE;
			for (int i = 0; i < ORIENT_WORDS; i++) orient_q[i] <= '0;
			for (int p = 0; p < PLANES; p++) plane_q[p] <= '0;
		end else begin
			if (res_valid_q && !out_stall) res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						case (q_item.op)
							OP_ORIENT: begin
								orient_q[q_item.idx] <= q_item.value;
							end
							OP_PLANE: begin
								for (int p = 0; p < PLANES; p++) begin
									if (32'(q_item.idx[3:2]) == p) begin
										plane_q[p][q_item.idx[1:0]] <= q_item.value;
									end
								end
							end
							default: begin
								bmin_q   <= q_item.bmin;
								bmax_q   <= q_item.bmax;
								k_q      <= '0;
								c_q      <= '0;
								p_q      <= '0;
								front_q  <= '0;
								back_q   <= '0;
								forced_q <= no_cull;
								state_q  <= no_cull ? ST_FIN : ST_XMUL;
							end
						endcase
					end
				end
				ST_XMUL: begin
					for (int i = 0; i < 3; i++) prod_q[i] <= axis[i] * loc[i];
					state_q <= ST_XSUM;
				end
				ST_XSUM: begin
					pt_q[c_q] <= xsat;
					if (c_q == 2'd2) begin
						c_q     <= '0;
						p_q     <= '0;
						state_q <= ST_DMUL;
					end else begin
						c_q     <= c_q + 2'd1;
						state_q <= ST_XMUL;
					end
				end
				ST_DMUL: begin
					for (int i = 0; i < 3; i++) prod_q[i] <= pt_q[i] * plane_q[p_q][i];
					state_q <= ST_DCMP;
				end
				ST_DCMP: begin
					front_q[p_q] <= front_q[p_q] | gt;
					back_q[p_q]  <= back_q[p_q] | !gt;
					if (p_q == PW'(PLANES - 1)) begin
						p_q <= '0;
						if (k_q == 3'd7) begin
							state_q <= ST_FIN;
						end else begin
							k_q     <= k_q + 3'd1;
							state_q <= ST_XMUL;
						end
					end else begin
						p_q     <= p_q + PW'(1);
						state_q <= ST_DMUL;
					end
				end
				ST_FIN: begin
					// hold until the result register is free
					if (!res_valid_q || !out_stall) begin
						res_valid_q <= 1'b1;
						verdict_q   <= final_verdict;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (verdict == VERDICT_INSIDE || verdict == VERDICT_CLIP
		|| verdict == VERDICT_OUTSIDE)) else $error("bad verdict code");
	a_last_test: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DCMP && k_q == 3'd7 && p_q == PW'(PLANES - 1))
		|=> state_q == ST_FIN) else $error("missed finish after last test");
	a_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		(q_take && q_item.op == OP_CULL && no_cull) |=> state_q == ST_FIN)
		else $error("no-cull item did not bypass tests");
	a_coord_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_XSUM |-> c_q != 2'd3) else $error("coordinate counter overrun");
`endif

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb
// Drives load and cull items into the frustum cull block, predicts each
// verdict with a fixed-point model of its own and checks results in order.
// -----------------------------------------------------------------------------
module tb;
	import obfc_pkg::*;

	localparam int PLANES    = 4;
	localparam int FRAC      = 16;
	localparam int PLANE_WDS = 4 * PLANES;
	localparam int STALL_LIMIT = 20000;

	// Verdict scoreboard: holds the orientation and plane words, predicts
	// each cull item and checks results in arrival order.
	class verdict_board;
		logic signed [31:0] orient [ORIENT_WORDS];
		logic signed [31:0] plane [PLANE_WDS];
		bit                 no_cull;
		logic [1:0]         pending [$];
		int                 errors;

		function new();
			foreach (orient[i]) orient[i] = '0;
			foreach (plane[i]) plane[i] = '0;
			no_cull = 0;
			errors = 0;
		endfunction

		// World coordinate c of a local point, rounded and saturated.
		function logic signed [31:0] to_world(int c, logic signed [31:0] p [3]);
			logic signed [127:0] acc;
			logic signed [127:0] sh;
			acc = 128'(orient[c]) <<< FRAC;
			for (int i = 0; i < 3; i++)
				acc += 128'(orient[3 + 3 * i + c]) * 128'(p[i]);
			acc += 128'sd1 <<< (FRAC - 1);
			sh = acc >>> FRAC;
			if (sh > 128'sd2147483647) return 32'sh7fffffff;
			if (sh < -128'sd2147483648) return 32'sh80000000;
			return sh[31:0];
		endfunction

		function logic [1:0] classify(logic signed [31:0] bmn [3],
				logic signed [31:0] bmx [3]);
			logic signed [31:0] pts [8][3];
			logic signed [31:0] loc [3];
			logic signed [127:0] dot, dist_w;
			logic [1:0] v;
			bit front, back;
			if (no_cull) return VERDICT_CLIP;
			for (int k = 0; k < 8; k++) begin
				for (int c = 0; c < 3; c++)
					loc[c] = k[c] ? bmx[c] : bmn[c];
				for (int c = 0; c < 3; c++)
					pts[k][c] = to_world(c, loc);
			end
			v = VERDICT_INSIDE;
			for (int p = 0; p < PLANES; p++) begin
				front = 0;
				back = 0;
				dist_w = 128'(plane[4 * p + 3]) <<< FRAC;
				for (int k = 0; k < 8; k++) begin
					dot = 0;
					for (int c = 0; c < 3; c++)
						dot += 128'(pts[k][c]) * 128'(plane[4 * p + c]);
					if (dot > dist_w) front = 1;
					else back = 1;
				end
				if (!front) return VERDICT_OUTSIDE;
				if (back) v = VERDICT_CLIP;
			end
			return v;
		endfunction

		function void note_item(logic [1:0] f, logic [3:0] idx, logic signed [31:0] val,
				logic signed [31:0] bmn [3], logic signed [31:0] bmx [3]);
			if (f == FUNC_CULL)
				pending.push_back(classify(bmn, bmx));
			else if (f == FUNC_ORIENT && idx < ORIENT_WORDS)
				orient[idx] = val;
			else if (f == FUNC_PLANE && idx < PLANE_WDS)
				plane[idx] = val;
		endfunction

		function void check_verdict(logic [1:0] got);
			logic [1:0] want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected verdict %0d", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("verdict mismatch: expected %0d actual %0d", want, got);
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall;
	logic [1:0] func = '0;
	logic [3:0] word_index = '0;
	word_t word_value = '0;
	word_t box_min_x = '0, box_min_y = '0, box_min_z = '0;
	word_t box_max_x = '0, box_max_y = '0, box_max_z = '0;
	logic out_valid, out_stall = 0;
	logic [1:0] verdict;
	logic cfg_valid = 0, cfg_ready, cfg_data = 0;

	verdict_board board = new();
	int send_idle = 0;   // percent of cycles the sender idles
	int recv_idle = 0;   // percent of cycles the receiver stalls
	int hold_cycles = 0; // long receiver hold-off, counted down in its own process
	int quiet = 0;

	always #5 clk = ~clk;

	oriented_box_frustum_cull_top #(.PLANES(PLANES), .FRAC_BITS(FRAC)) dut (.*);

	// Receiver stall: random per phase, or held high through a hold-off.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1;
			hold_cycles <= hold_cycles - 1;
		end else
			out_stall <= ($urandom_range(99) < recv_idle);
	end

	// Check results at the rising edge; watchdog counts cycles with no transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_verdict(verdict);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	function automatic word_t rand_word();
		case ($urandom_range(5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return word_t'($urandom_range(131071)) - 32'sd65536;
			3: return word_t'($urandom_range(2097151)) - 32'sd1048576;
			default: return word_t'($urandom());
		endcase
	endfunction

	// Offer one item and hold it until accepted; valid stays up for the next item.
	task automatic send_item(logic [1:0] f, logic [3:0] idx, word_t val,
			word_t mnx, word_t mny, word_t mnz, word_t mxx, word_t mxy, word_t mxz);
		logic signed [31:0] bmn [3];
		logic signed [31:0] bmx [3];
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(negedge clk);
		end
		func <= f; word_index <= idx; word_value <= val;
		box_min_x <= mnx; box_min_y <= mny; box_min_z <= mnz;
		box_max_x <= mxx; box_max_y <= mxy; box_max_z <= mxz;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		bmn = '{mnx, mny, mnz};
		bmx = '{mxx, mxy, mxz};
		board.note_item(f, idx, val, bmn, bmx);
		@(negedge clk);
	endtask

	task automatic load(logic [1:0] f, logic [3:0] idx, word_t val);
		send_item(f, idx, val, word_t'($urandom()), word_t'($urandom()),
			word_t'($urandom()), word_t'($urandom()), word_t'($urandom()),
			word_t'($urandom()));
	endtask

	task automatic cull(word_t mnx, word_t mny, word_t mnz, word_t mxx, word_t mxy, word_t mxz);
		send_item(FUNC_CULL, 4'($urandom()), word_t'($urandom()),
			mnx, mny, mnz, mxx, mxy, mxz);
	endtask

	// Small box around a center, mostly well ordered.
	task automatic rand_cull();
		word_t c [3];
		word_t h [3];
		for (int i = 0; i < 3; i++) begin
			c[i] = word_t'($urandom_range(20 << 16)) - word_t'(10 << 16);
			h[i] = word_t'($urandom_range(4 << 16));
		end
		if ($urandom_range(9) == 0)
			cull(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
		else
			cull(c[0] - h[0], c[1] - h[1], c[2] - h[2], c[0] + h[0], c[1] + h[1], c[2] + h[2]);
	endtask

	// Drain, allow in-flight work to finish, then write no_cull.
	task automatic write_no_cull(bit v);
		int n;
		n = 0;
		in_valid <= 0;
		while (board.pending.size() != 0 && n < 200000) begin
			@(negedge clk);
			n++;
		end
		repeat (150) @(negedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		board.no_cull = v;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// Plausible frustum: identity-ish orientation, random plane normals with non-positive offsets.
	task automatic rand_scene();
		for (int i = 0; i < ORIENT_WORDS; i++)
			if ($urandom_range(7) == 0)
				load(FUNC_ORIENT, 4'(i), rand_word());
			else if (i >= 3)
				load(FUNC_ORIENT, 4'(i), ((i - 3) % 4 == 0) ? (32'sd1 <<< 16)
					: word_t'($urandom_range(32768)) - 32'sd16384);
			else
				load(FUNC_ORIENT, 4'(i),
					word_t'($urandom_range(4 << 16)) - word_t'(2 << 16));
		for (int p = 0; p < PLANES; p++)
			for (int c = 0; c < 4; c++)
				load(FUNC_PLANE, 4'(4 * p + c), (c == 3)
					? -word_t'($urandom_range(12 << 16))
					: word_t'($urandom_range(2 << 16)) - word_t'(1 << 16));
	endtask

	initial begin
		int ph_send [4] = '{0, 47, 0, 36};
		int ph_recv [4] = '{0, 0, 47, 36};
		repeat (2) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Directed: zero stores give outside, then extremes and odd codes.
		cull(0, 0, 0, 0, 0, 0);
		cull(32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		send_item(2'd3, 4'hf, 32'sh7fffffff, 0, 0, 0, 0, 0, 0);
		load(FUNC_ORIENT, 4'd12, 32'sh12345678);
		load(FUNC_ORIENT, 4'd15, 32'sh80000000);
		for (int i = 0; i < ORIENT_WORDS; i++)
			load(FUNC_ORIENT, 4'(i),
				(i == 3 || i == 7 || i == 11) ? 32'sh7fffffff : 32'sh80000000);
		cull(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
		load(FUNC_PLANE, 4'd0, 32'sh00010000);
		load(FUNC_PLANE, 4'd3, 32'sh80000000);
		cull(32'sh00010000, 0, 0, 32'shffff0000, 0, 0);
		write_no_cull(1);
		cull(0, 0, 0, 0, 0, 0);
		load(FUNC_PLANE, 4'd15, 32'sh7fffffff);
		cull(32'sh80000000, 0, 0, 32'sh7fffffff, 0, 0);
		write_no_cull(0);

		// Random phases, each with its own idling mix.
		for (int ph = 0; ph < 8; ph++) begin
			send_idle = ph_send[ph % 4];
			recv_idle = ph_recv[ph % 4];
			if (ph == 4 || ph == 7)
				write_no_cull(ph == 4);
			rand_scene();
			if (ph == 2) hold_cycles = 3000;
			for (int n = 0; n < 163; n++) begin
				if ($urandom_range(19) == 0)
					load(2'($urandom_range(3)), 4'($urandom()), rand_word());
				else
					rand_cull();
			end
		end

		// Drain: wait for all verdicts, then linger for in-flight work.
		in_valid <= 0;
		recv_idle = 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (board.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

[sim.f]
rtl/obfc_pkg.sv
rtl/obfc_front.sv
rtl/obfc_back.sv
rtl/oriented_box_frustum_cull_top.sv
verif/tb.sv
